// ----- hw/rtl/joystick_axis_deadzone_map_core_macros.svh -----
// Assertion macros shared by the joystick axis map RTL.
`ifndef JOYSTICK_AXIS_DEADZONE_MAP_CORE_MACROS_SVH
`define JOYSTICK_AXIS_DEADZONE_MAP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define JADM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("joystick axis map assertion failed");
// checked on every clock edge, reset included
`define JADM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("joystick axis map assertion failed");
`else
`define JADM_ASSERT(lbl, prop)
`define JADM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/jadm_pkg.sv -----
// Types, constants and the divider step function of the joystick axis map.
`timescale 1ns / 1ps

package jadm_pkg;

  // sample width of the ADC stream
  localparam int SAMPLE_BITS = 12;
  localparam int TGT_W       = 11;
  localparam int OUT_W       = 23;

  // derived datapath widths
  localparam int SPAN_W  = SAMPLE_BITS + 2;          // thresholds, spans (signed)
  localparam int DIFF_W  = SAMPLE_BITS + 1;          // x - start (signed)
  localparam int TGTN_W  = TGT_W + 1;                // target after negation
  localparam int PROD_W  = DIFF_W + TGTN_W;          // signed product
  localparam int NUM_W   = SAMPLE_BITS + TGT_W - 1;  // |product|
  localparam int DEN_W   = SAMPLE_BITS + 1;          // |span|

  // divider: quotient bits resolved per stage
  localparam int DSTEP      = 4;
  localparam int DIV_STAGES = (NUM_W + DSTEP - 1) / DSTEP;
  localparam int NQ_W       = DIV_STAGES * DSTEP;

  // APB register file
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = ADDR_W - 2;

  typedef logic        [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [TGT_W-1:0]       tgt_t;
  typedef logic signed [TGTN_W-1:0]      tgtn_t;
  typedef logic signed [SPAN_W-1:0]      wide_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic        [NUM_W-1:0]       num_t;
  typedef logic        [DEN_W-1:0]       den_t;
  typedef logic        [NQ_W-1:0]        nq_t;
  typedef logic signed [OUT_W-1:0]       out_val_t;
  typedef logic        [1:0]             zone_t;
  typedef logic        [REG_IDX_W-1:0]   reg_idx_t;

  // zone codes
  localparam zone_t ZONE_DEAD = 2'd0;
  localparam zone_t ZONE_HIGH = 2'd1;
  localparam zone_t ZONE_LOW  = 2'd2;

  // register indexes
  localparam reg_idx_t REG_CENTER   = 3'd0;
  localparam reg_idx_t REG_LOW_END  = 3'd1;
  localparam reg_idx_t REG_HIGH_END = 3'd2;
  localparam reg_idx_t REG_DEAD     = 3'd3;
  localparam reg_idx_t REG_HIGH_TGT = 3'd4;
  localparam reg_idx_t REG_LOW_TGT  = 3'd5;
  localparam reg_idx_t REG_INVERT   = 3'd6;

  // reset values
  localparam smp_t CENTER_RST   = smp_t'(0);
  localparam smp_t LOW_END_RST  = smp_t'(4095);
  localparam smp_t HIGH_END_RST = smp_t'(0);
  localparam smp_t DEAD_RST     = smp_t'(60);
  localparam tgt_t HIGH_TGT_RST = tgt_t'(10);
  localparam tgt_t LOW_TGT_RST  = tgt_t'(-10);
  localparam logic INVERT_RST   = 1'b1;

  // sideband that rides along the divider
  typedef struct packed {
    logic  neg;
    logic  fault;
    zone_t zone;
  } div_side_t;

  // partial remainder and the dividend/quotient shift word
  typedef struct packed {
    den_t rem;
    nq_t  nq;
  } div_state_t;

  // one restoring division step
  function automatic div_state_t div_step(div_state_t s, den_t den);
    logic [DEN_W:0] trial;
    logic           qbit;
    div_state_t     r;
    trial = {s.rem, s.nq[NQ_W-1]};
    qbit  = (trial >= {1'b0, den});
    if (qbit) begin
      r.rem = den_t'(trial - {1'b0, den});
    end else begin
      r.rem = trial[DEN_W-1:0];
    end
    r.nq = {s.nq[NQ_W-2:0], qbit};
    return r;
  endfunction

endpackage

// ----- hw/rtl/jadm_div.sv -----
// Pipelined unsigned restoring divider with per-stage valid and backpressure.
`timescale 1ns / 1ps

module jadm_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jadm_pkg::num_t      num,
  input  jadm_pkg::den_t      den,
  input  jadm_pkg::div_side_t side_in,
  output logic                out_valid,
  input  logic                out_ready,
  output jadm_pkg::num_t      quo,
  output jadm_pkg::div_side_t side_out
);

  logic                 v_r    [jadm_pkg::DIV_STAGES];
  logic                 rdy    [jadm_pkg::DIV_STAGES];
  jadm_pkg::div_state_t st_r   [jadm_pkg::DIV_STAGES];
  jadm_pkg::den_t       den_r  [jadm_pkg::DIV_STAGES];
  jadm_pkg::div_side_t  side_r [jadm_pkg::DIV_STAGES];

  for (genvar k = 0; k < jadm_pkg::DIV_STAGES; k++) begin : g_stage
    jadm_pkg::div_state_t st_in;
    jadm_pkg::div_state_t st_out;
    jadm_pkg::den_t       den_in;
    jadm_pkg::div_side_t  side_k;
    logic                 v_in;

    // stage input: module ports for the head, previous stage otherwise
    if (k == 0) begin : g_head
      assign st_in.rem = '0;
      assign st_in.nq  = jadm_pkg::nq_t'(num);
      assign den_in    = den;
      assign side_k    = side_in;
      assign v_in      = in_valid;
    end else begin : g_body
      assign st_in  = st_r[k-1];
      assign den_in = den_r[k-1];
      assign side_k = side_r[k-1];
      assign v_in   = v_r[k-1];
    end

    // stage may load when empty or when the next one takes its beat
    if (k == jadm_pkg::DIV_STAGES - 1) begin : g_tail
      assign rdy[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    // DSTEP quotient bits per stage
    always_comb begin
      st_out = st_in;
      for (int i = 0; i < jadm_pkg::DSTEP; i++) begin
        st_out = jadm_pkg::div_step(st_out, den_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k]   <= st_out;
        den_r[k]  <= den_in;
        side_r[k] <= side_k;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[jadm_pkg::DIV_STAGES-1];
  assign quo       = jadm_pkg::num_t'(st_r[jadm_pkg::DIV_STAGES-1].nq);
  assign side_out  = side_r[jadm_pkg::DIV_STAGES-1];

endmodule

// ----- hw/rtl/joystick_axis_deadzone_map_core.sv -----
// Top level of the joystick axis dead-zone map: registers, front pipeline, divider, output stage.
`timescale 1ns / 1ps
`include "joystick_axis_deadzone_map_core_macros.svh"

// Maps one raw ADC sample of a joystick axis to a signed control value with a
// dead zone around the calibrated center and a linear scale out to each end.
// One sample is taken every cycle while in_stall is low; a result passes through
// five front stages (capture, zone select, subtract, multiply, magnitude), the
// divider resolving four quotient bits per stage, and the output register.
// Stalls ripple back only through occupied stages, so empty stages keep filling
// while a result waits. Calibration registers sit on an APB port at byte address
// 4*index and must be written only while the pipeline is empty.

module joystick_axis_deadzone_map_core (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jadm_pkg::ADDR_W-1:0]   paddr,
  input  logic [jadm_pkg::DATA_W-1:0]   pwdata,
  output logic [jadm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jadm_pkg::smp_t                raw_sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output jadm_pkg::out_val_t            mapped_value,
  output jadm_pkg::zone_t               zone,
  output logic                          divide_fault
);

  // ---------------------------------------------------------------- registers
  jadm_pkg::smp_t   center_point;
  jadm_pkg::smp_t   low_end;
  jadm_pkg::smp_t   high_end;
  jadm_pkg::smp_t   dead_band;
  jadm_pkg::tgt_t   high_target;
  jadm_pkg::tgt_t   low_target;
  logic             invert;
  jadm_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[jadm_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_point <= jadm_pkg::CENTER_RST;
      low_end      <= jadm_pkg::LOW_END_RST;
      high_end     <= jadm_pkg::HIGH_END_RST;
      dead_band    <= jadm_pkg::DEAD_RST;
      high_target  <= jadm_pkg::HIGH_TGT_RST;
      low_target   <= jadm_pkg::LOW_TGT_RST;
      invert       <= jadm_pkg::INVERT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        jadm_pkg::REG_CENTER:   center_point <= pwdata[jadm_pkg::SAMPLE_BITS-1:0];
        jadm_pkg::REG_LOW_END:  low_end      <= pwdata[jadm_pkg::SAMPLE_BITS-1:0];
        jadm_pkg::REG_HIGH_END: high_end     <= pwdata[jadm_pkg::SAMPLE_BITS-1:0];
        jadm_pkg::REG_DEAD:     dead_band    <= pwdata[jadm_pkg::SAMPLE_BITS-1:0];
        jadm_pkg::REG_HIGH_TGT: high_target  <= pwdata[jadm_pkg::TGT_W-1:0];
        jadm_pkg::REG_LOW_TGT:  low_target   <= pwdata[jadm_pkg::TGT_W-1:0];
        jadm_pkg::REG_INVERT:   invert       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // readback, zero extended
  always_comb begin
    case (reg_idx)
      jadm_pkg::REG_CENTER:   prdata = jadm_pkg::DATA_W'(center_point);
      jadm_pkg::REG_LOW_END:  prdata = jadm_pkg::DATA_W'(low_end);
      jadm_pkg::REG_HIGH_END: prdata = jadm_pkg::DATA_W'(high_end);
      jadm_pkg::REG_DEAD:     prdata = jadm_pkg::DATA_W'(dead_band);
      jadm_pkg::REG_HIGH_TGT: prdata = jadm_pkg::DATA_W'($unsigned(high_target));
      jadm_pkg::REG_LOW_TGT:  prdata = jadm_pkg::DATA_W'($unsigned(low_target));
      jadm_pkg::REG_INVERT:   prdata = jadm_pkg::DATA_W'(invert);
      default:                prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ stage control
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic div_in_ready;
  logic div_out_valid;

  assign rdy_out = !out_valid || !out_stall;
  assign rdy5    = !v5 || div_in_ready;
  assign rdy4    = !v4 || rdy5;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // ------------------------------------------------------- stage 1: capture
  jadm_pkg::smp_t raw1;

  always_ff @(posedge clk) begin
    if (rdy1) raw1 <= raw_sample;
  end

  // ----------------------------------------------- stage 2: zone and operands
  jadm_pkg::wide_t xs;
  jadm_pkg::wide_t thr_hi;
  jadm_pkg::wide_t thr_lo;
  jadm_pkg::zone_t zone_next;
  jadm_pkg::wide_t start_next;
  jadm_pkg::wide_t end_next;
  jadm_pkg::tgtn_t tgt_sel;
  jadm_pkg::tgtn_t tgt_next;

  always_comb begin
    xs     = jadm_pkg::wide_t'(raw1);
    thr_hi = jadm_pkg::wide_t'(center_point) + jadm_pkg::wide_t'(dead_band);
    thr_lo = jadm_pkg::wide_t'(center_point) - jadm_pkg::wide_t'(dead_band);
    if (xs > thr_hi) begin
      zone_next  = jadm_pkg::ZONE_HIGH;
      start_next = thr_hi;
      end_next   = jadm_pkg::wide_t'(high_end);
      tgt_sel    = jadm_pkg::tgtn_t'(high_target);
    end else if (xs < thr_lo) begin
      zone_next  = jadm_pkg::ZONE_LOW;
      start_next = thr_lo;
      end_next   = jadm_pkg::wide_t'(low_end);
      tgt_sel    = jadm_pkg::tgtn_t'(low_target);
    end else begin
      // dead zone: zero target, result forced at the output anyway
      zone_next  = jadm_pkg::ZONE_DEAD;
      start_next = xs;
      end_next   = xs;
      tgt_sel    = '0;
    end
    tgt_next = invert ? -tgt_sel : tgt_sel;
  end

  jadm_pkg::smp_t  x2;
  jadm_pkg::zone_t zone2;
  jadm_pkg::wide_t start2;
  jadm_pkg::wide_t end2;
  jadm_pkg::tgtn_t tgt2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2     <= raw1;
      zone2  <= zone_next;
      start2 <= start_next;
      end2   <= end_next;
      tgt2   <= tgt_next;
    end
  end

  // --------------------------------------------------- stage 3: offsets, span
  jadm_pkg::wide_t diff_wide;
  jadm_pkg::diff_t diff3;
  jadm_pkg::wide_t span3;
  jadm_pkg::tgtn_t tgt3;
  jadm_pkg::zone_t zone3;

  assign diff_wide = jadm_pkg::wide_t'(x2) - start2;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      diff3 <= jadm_pkg::diff_t'(diff_wide);
      span3 <= end2 - start2;
      tgt3  <= tgt2;
      zone3 <= zone2;
    end
  end

  // ------------------------------------------- stage 4: multiply, |span|
  jadm_pkg::wide_t span_abs;
  jadm_pkg::prod_t prod4;
  jadm_pkg::den_t  den4;
  logic            span_neg4;
  logic            fault4;
  jadm_pkg::zone_t zone4;

  assign span_abs = span3[jadm_pkg::SPAN_W-1] ? -span3 : span3;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      prod4     <= jadm_pkg::prod_t'(diff3) * jadm_pkg::prod_t'(tgt3);
      den4      <= jadm_pkg::den_t'(span_abs);
      span_neg4 <= span3[jadm_pkg::SPAN_W-1];
      fault4    <= (zone3 != jadm_pkg::ZONE_DEAD) && (span3 == '0);
      zone4     <= zone3;
    end
  end

  // ------------------------------------------------- stage 5: |product|, sign
  jadm_pkg::prod_t     prod_abs;
  jadm_pkg::num_t      num5;
  jadm_pkg::den_t      den5;
  jadm_pkg::div_side_t side5;

  assign prod_abs = prod4[jadm_pkg::PROD_W-1] ? -prod4 : prod4;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      num5        <= jadm_pkg::num_t'(prod_abs);
      den5        <= den4;
      side5.neg   <= prod4[jadm_pkg::PROD_W-1] ^ span_neg4;
      side5.fault <= fault4;
      side5.zone  <= zone4;
    end
  end

  // ------------------------------------------------------------------ divider
  jadm_pkg::num_t      quo;
  jadm_pkg::div_side_t side_q;

  jadm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_ready  (div_in_ready),
    .num       (num5),
    .den       (den5),
    .side_in   (side5),
    .out_valid (div_out_valid),
    .out_ready (rdy_out),
    .quo       (quo),
    .side_out  (side_q)
  );

  // ------------------------------------------------ output: sign and register
  logic signed [jadm_pkg::NUM_W:0] quo_s;
  logic signed [jadm_pkg::NUM_W:0] quo_signed;
  jadm_pkg::out_val_t              mapped_next;

  always_comb begin
    quo_s      = {1'b0, quo};
    quo_signed = side_q.neg ? -quo_s : quo_s;
    if (side_q.fault || (side_q.zone == jadm_pkg::ZONE_DEAD)) begin
      mapped_next = '0;
    end else begin
      mapped_next = jadm_pkg::out_val_t'(quo_signed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_out) begin
      out_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      mapped_value <= mapped_next;
      zone         <= side_q.zone;
      divide_fault <= side_q.fault;
    end
  end

  // --------------------------------------------------------------- assertions
  `JADM_ASSERT(a_accept_fills, (in_valid && !in_stall) |=> v1)
  `JADM_ASSERT(a_fault_zero, out_valid |-> (!divide_fault || mapped_value == '0))
  `JADM_ASSERT(a_dead_clean, (out_valid && zone == jadm_pkg::ZONE_DEAD) |-> (mapped_value == '0 && !divide_fault))
  `JADM_ASSERT_ALWAYS(a_rst_flush, rst |=> (!out_valid && !v1 && !v5))

endmodule
